/* hdl/sss_pkg.sv */
package sss_pkg;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int TGT_W    = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_PEEK     = 3'd2,
        KIND_LOOKUP   = 3'd3,
        KIND_POP_TO   = 3'd4,
        KIND_EXIT     = 3'd5
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic CFG_STRONG = 1'b0;
    localparam logic CFG_WEAK   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                latch_req;
        logic                load_ptr;
        logic                step_ptr;
        logic                do_push;
        logic                count_from_ptr;
        logic                trim_count;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                capture_entry;
        logic                capture_pos;
        logic                load_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              full;
        logic              ptr_one;
        logic              is_strong;
        logic              is_weak;
        logic              key_match;
        logic              type_match;
        logic              out_busy;
    } stat_t;

endpackage

/* hdl/sss_ctrl.sv */
module sss_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sss_pkg::stat_t stat,
    output sss_pkg::cmd_t  cmd
);
    import sss_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_req = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FINISH;
                case (stat.kind)
                    KIND_PUSH: begin
                        if (stat.full) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_FULL;
                        end else begin
                            cmd.do_push = 1'b1;
                        end
                    end
                    KIND_POP, KIND_PEEK, KIND_EXIT: begin
                        if (stat.count_zero) begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_EMPTY;
                        end else begin
                            cmd.load_ptr = 1'b1;
                            state_next   = S_CHECK;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (!stat.count_zero) begin
                            cmd.load_ptr = 1'b1;
                            state_next   = S_CHECK;
                        end
                    end
                    KIND_POP_TO: begin
                        cmd.trim_count = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_CHECK: begin
                state_next = S_FINISH;
                case (stat.kind)
                    KIND_POP: begin
                        cmd.capture_entry  = 1'b1;
                        cmd.count_from_ptr = 1'b1;
                    end
                    KIND_PEEK: begin
                        cmd.capture_entry = 1'b1;
                    end
                    KIND_EXIT: begin
                        cmd.count_from_ptr = 1'b1;
                        if (!stat.type_match && !stat.ptr_one) begin
                            cmd.step_ptr = 1'b1;
                            state_next   = S_CHECK;
                        end
                    end
                    KIND_LOOKUP: begin
                        if (stat.is_strong) begin
                            state_next = S_FINISH;
                        end else if (!stat.is_weak && stat.key_match) begin
                            cmd.capture_entry = 1'b1;
                            cmd.capture_pos   = 1'b1;
                        end else if (!stat.ptr_one) begin
                            cmd.step_ptr = 1'b1;
                            state_next   = S_CHECK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/sss_datapath.sv */
module sss_datapath #(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int TYPE_WIDTH  = 4,
    parameter int IN_DW       = 80,
    parameter int OUT_DW      = 88
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [IN_DW-1:0]        s_tdata,
    input  logic [sss_pkg::KIND_W-1:0] s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DW-1:0]       m_tdata,
    output logic [2:0]              m_tuser,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [TYPE_WIDTH-1:0]   cfg_wdata,
    input  sss_pkg::cmd_t           cmd,
    output sss_pkg::stat_t          stat
);
    import sss_pkg::*;

    localparam int KW   = KEY_WIDTH;
    localparam int VW   = VALUE_WIDTH;
    localparam int TW   = TYPE_WIDTH;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int EW   = KW + TW + VW;
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int OUTW = KW + TW + VW + AW + CW;

    logic [EW-1:0] mem [DEPTH];

    logic [TW-1:0]       strong_reg;
    logic [TW-1:0]       weak_reg;
    logic [KIND_W-1:0]   req_kind_reg;
    logic [KW-1:0]       req_key_reg;
    logic [TW-1:0]       req_type_reg;
    logic [VW-1:0]       req_value_reg;
    logic [TGT_W-1:0]    req_target_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       ptr_reg;
    logic [CW-1:0]       ptr_next;
    logic [CW-1:0]       ptr_dec;
    logic [AW-1:0]       rd_addr;
    logic [EW-1:0]       rd_data_reg;
    logic [KW-1:0]       rd_key;
    logic [TW-1:0]       rd_type;
    logic [VW-1:0]       rd_value;
    logic                res_hit_reg;
    logic [KW-1:0]       res_key_reg;
    logic [TW-1:0]       res_type_reg;
    logic [VW-1:0]       res_value_reg;
    logic [AW-1:0]       res_pos_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                m_tvalid_reg;
    logic [OUT_DW-1:0]   m_tdata_reg;
    logic [2:0]          m_tuser_reg;
    logic [CMPW-1:0]     limit;

    assign rd_key   = rd_data_reg[KW-1:0];
    assign rd_type  = rd_data_reg[KW +: TW];
    assign rd_value = rd_data_reg[KW+TW +: VW];
    assign ptr_dec  = ptr_reg - CW'(1);

    assign limit = (req_target_reg[TGT_W-1] ? CMPW'(0) : CMPW'(req_target_reg[TGT_W-2:0]))
                   + CMPW'(1);

    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load_ptr) begin
            ptr_next = count_reg;
        end else if (cmd.step_ptr) begin
            ptr_next = ptr_dec;
        end
        rd_addr = AW'(ptr_next - CW'(1));
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.do_push) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.count_from_ptr) begin
            count_next = ptr_dec;
        end else if (cmd.trim_count) begin
            if (CMPW'(count_reg) > limit) begin
                count_next = CW'(limit);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strong_reg   <= TW'(1);
            weak_reg     <= TW'(2);
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_STRONG: strong_reg <= cfg_wdata;
                    CFG_WEAK:   weak_reg   <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        rd_data_reg <= mem[rd_addr];
        if (cmd.do_push) begin
            mem[count_reg[AW-1:0]] <= {req_value_reg, req_type_reg, req_key_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_req) begin
            req_kind_reg   <= s_tuser;
            req_key_reg    <= s_tdata[KW-1:0];
            req_type_reg   <= s_tdata[KW +: TW];
            req_value_reg  <= s_tdata[KW+TW +: VW];
            req_target_reg <= s_tdata[KW+TW+VW +: TGT_W];
            res_hit_reg    <= 1'b0;
            res_key_reg    <= '0;
            res_type_reg   <= '0;
            res_value_reg  <= '0;
            res_pos_reg    <= '0;
            res_status_reg <= ST_OK;
        end else begin
            if (cmd.set_status) begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.capture_entry) begin
                res_hit_reg   <= 1'b1;
                res_key_reg   <= rd_key;
                res_type_reg  <= rd_type;
                res_value_reg <= rd_value;
            end
            if (cmd.capture_pos) begin
                res_pos_reg <= ptr_dec[AW-1:0];
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= OUT_DW'({count_reg, res_pos_reg, res_value_reg, res_type_reg,
                                    res_key_reg});
            m_tuser_reg <= {res_status_reg, res_hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        stat            = '0;
        stat.kind       = req_kind_reg;
        stat.count_zero = (count_reg == '0);
        stat.full       = (count_reg == CW'(DEPTH));
        stat.ptr_one    = (ptr_reg == CW'(1));
        stat.is_strong  = (rd_type == strong_reg);
        stat.is_weak    = (rd_type == weak_reg);
        stat.key_match  = (rd_key == req_key_reg);
        stat.type_match = (rd_type == req_type_reg);
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

endmodule

/* hdl/scoped_symbol_stack_top.sv */
// A request is taken only in idle and latched; then the block pushes, trims the stack for
// pop to index, or flags an empty or full stack, else loads the walk pointer for pop, peek,
// lookup and exit scope; lookup and exit scope walk down at most DEPTH entries.
// The result is loaded once the output is free, and no new request is taken until then;
// the walk reads one stack slot per cycle from a single registered memory read port.
// Reset (aresetn low, synchronous): stack empty, border codes 1 and 2, no result pending.
module scoped_symbol_stack_top #(
    parameter int DEPTH       = 64,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int TYPE_WIDTH  = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key, entry_type, entry_value, target_index
    input  logic [((KEY_WIDTH+TYPE_WIDTH+VALUE_WIDTH+sss_pkg::TGT_W+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic [sss_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_key, out_type, out_value, position, occupancy
    output logic [((KEY_WIDTH+TYPE_WIDTH+VALUE_WIDTH+$clog2(DEPTH)+$clog2(DEPTH+1)+7)/8)*8-1:0]
                                                m_tdata,
    // hit, status
    output logic [2:0]                          m_tuser,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [TYPE_WIDTH-1:0]               cfg_wdata
);
    import sss_pkg::*;

    localparam int IN_DW  = ((KEY_WIDTH + TYPE_WIDTH + VALUE_WIDTH + TGT_W + 7) / 8) * 8;
    localparam int OUT_DW =
        ((KEY_WIDTH + TYPE_WIDTH + VALUE_WIDTH + $clog2(DEPTH) + $clog2(DEPTH + 1) + 7) / 8) * 8;

    cmd_t  cmd;
    stat_t stat;

    sss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sss_datapath #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .TYPE_WIDTH  (TYPE_WIDTH),
        .IN_DW       (IN_DW),
        .OUT_DW      (OUT_DW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* sim/tb_top.sv */
module tb_top;
    import sss_pkg::*;

    localparam int DEPTH   = 64;
    localparam int S_W     = 80;
    localparam int M_W     = 88;
    localparam int N_SEG   = 6;
    localparam int SEG_LEN = 200;

    typedef struct {
        logic [2:0]        kind;
        logic [31:0]       key;
        logic [3:0]        etype;
        logic [31:0]       value;
        logic signed [6:0] tgt;
    } sym_req_t;

    typedef struct {
        logic        hit;
        logic [31:0] key;
        logic [3:0]  etype;
        logic [31:0] value;
        logic [5:0]  pos;
        logic [1:0]  status;
        logic [6:0]  occ;
    } sym_res_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic [2:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic [2:0]     m_tuser;
    logic           cfg_we = 1'b0;
    logic           cfg_index = 1'b0;
    logic [3:0]     cfg_wdata = '0;

    // symbol stack mirror
    logic [31:0] key_mem [DEPTH];
    logic [3:0]  type_mem [DEPTH];
    logic [31:0] val_mem [DEPTH];
    int          stack_cnt = 0;
    logic [3:0]  strong_code = 4'd1;
    logic [3:0]  weak_code = 4'd2;

    sym_res_t pending_results[$];
    sym_req_t directed_reqs[$];
    bit       directed_fixed_on[$];
    sym_res_t directed_fixed[$];

    sym_req_t cur_req;
    bit       cur_fixed_on = 1'b0;
    sym_res_t cur_fixed;

    int req_count = 0;
    int resp_count = 0;
    int err_count = 0;
    int snd_idle = 0;
    int rcv_idle = 0;
    logic [31:0] key_pool [8];

    scoped_symbol_stack_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic sym_res_t stack_apply(input sym_req_t r);
        sym_res_t o;
        int       i;
        int       tgt;
        bit       done;
        o = '{hit: 1'b0, key: '0, etype: '0, value: '0, pos: '0, status: ST_OK, occ: '0};
        case (r.kind)
            KIND_PUSH: begin
                if (stack_cnt >= DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    key_mem[stack_cnt] = r.key;
                    type_mem[stack_cnt] = r.etype;
                    val_mem[stack_cnt] = r.value;
                    stack_cnt++;
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (stack_cnt == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.hit = 1'b1;
                    o.key = key_mem[stack_cnt-1];
                    o.etype = type_mem[stack_cnt-1];
                    o.value = val_mem[stack_cnt-1];
                    if (r.kind == KIND_POP) stack_cnt--;
                end
            end
            KIND_LOOKUP: begin
                i = stack_cnt;
                done = 1'b0;
                while (i > 0 && !done) begin
                    i--;
                    if (type_mem[i] == strong_code) begin
                        done = 1'b1;
                    end else if (type_mem[i] != weak_code && key_mem[i] == r.key) begin
                        o.hit = 1'b1;
                        o.key = key_mem[i];
                        o.etype = type_mem[i];
                        o.value = val_mem[i];
                        o.pos = i[5:0];
                        done = 1'b1;
                    end
                end
            end
            KIND_POP_TO: begin
                tgt = r.tgt[6] ? 0 : int'(r.tgt[5:0]);
                while (stack_cnt > tgt + 1) stack_cnt--;
            end
            KIND_EXIT: begin
                if (stack_cnt == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    done = 1'b0;
                    while (!done && stack_cnt > 0) begin
                        stack_cnt--;
                        if (type_mem[stack_cnt] == r.etype) done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        o.occ = stack_cnt[6:0];
        return o;
    endfunction

    function automatic sym_res_t mk_res(logic hit, logic [31:0] key, logic [3:0] etype,
                                        logic [31:0] value, logic [1:0] status, int occ);
        sym_res_t o;
        o = '{hit: hit, key: key, etype: etype, value: value, pos: '0, status: status,
              occ: occ[6:0]};
        return o;
    endfunction

    function automatic sym_req_t mk_req(logic [2:0] kind, logic [31:0] key,
                                        logic [3:0] etype, logic [31:0] value, int tgt);
        sym_req_t r;
        r = '{kind: kind, key: key, etype: etype, value: value, tgt: tgt[6:0]};
        return r;
    endfunction

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_type();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0) return strong_code;
        if (sel == 1) return weak_code;
        return $urandom_range(15);
    endfunction

    function automatic sym_req_t gen_request(int push_pct);
        sym_req_t r;
        int       sel;
        r = mk_req(KIND_PUSH, pick_key(), pick_type(), $urandom, $urandom_range(64) - 1);
        if ($urandom_range(99) < push_pct) return r;
        sel = $urandom_range(19);
        if (sel < 4) begin
            r.kind = KIND_POP;
        end else if (sel < 7) begin
            r.kind = KIND_PEEK;
        end else if (sel < 14) begin
            r.kind = KIND_LOOKUP;
            if (stack_cnt > 0 && $urandom_range(9) < 7)
                r.key = key_mem[$urandom_range(stack_cnt - 1)];
        end else if (sel < 16) begin
            r.kind = KIND_POP_TO;
            if ($urandom_range(1) == 1) r.tgt = 7'($urandom_range(stack_cnt) - 1);
        end else if (sel < 19) begin
            r.kind = KIND_EXIT;
            if (stack_cnt > 0 && $urandom_range(9) < 6)
                r.etype = type_mem[$urandom_range(stack_cnt - 1)];
        end else begin
            r.kind = 3'($urandom_range(6, 7));
        end
        return r;
    endfunction

    task automatic add_row(input sym_req_t r, input bit fixed_on, input sym_res_t fixed);
        directed_reqs.push_back(r);
        directed_fixed_on.push_back(fixed_on);
        directed_fixed.push_back(fixed);
    endtask

    task automatic send_req(input sym_req_t r, input bit fixed_on, input sym_res_t fixed);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, r.tgt, r.value, r.etype, r.key};
        s_tuser <= r.kind;
        cur_req <= r;
        cur_fixed_on <= fixed_on;
        cur_fixed <= fixed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        req_count++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (resp_count < req_count) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic idx, input logic [3:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_STRONG) strong_code = v;
        else weak_code = v;
    endtask

    task automatic chk_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // check results, then record the prediction for an accepted request
    always @(posedge aclk) begin
        sym_res_t exp_r;
        sym_res_t pred;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                resp_count++;
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h/%h",
                             $time, m_tuser, m_tdata);
                    err_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    chk_field("hit", exp_r.hit, m_tuser[0]);
                    chk_field("status", exp_r.status, m_tuser[2:1]);
                    chk_field("out_key", exp_r.key, m_tdata[31:0]);
                    chk_field("out_type", exp_r.etype, m_tdata[35:32]);
                    chk_field("out_value", exp_r.value, m_tdata[67:36]);
                    chk_field("position", exp_r.pos, m_tdata[73:68]);
                    chk_field("occupancy", exp_r.occ, m_tdata[80:74]);
                end
            end
            if (s_tvalid && s_tready) begin
                pred = stack_apply(cur_req);
                pending_results.push_back(cur_fixed_on ? cur_fixed : pred);
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
    end

    initial begin
        sym_res_t none;
        sym_req_t r;
        int       push_pct;
        logic [3:0] strong_set [N_SEG];
        logic [3:0] weak_set [N_SEG];
        strong_set = '{4'd0, 4'd15, 4'd7, 4'd3, 4'd1, 4'd15};
        weak_set   = '{4'd15, 4'd0, 4'd7, 4'd9, 4'd2, 4'd15};
        none = mk_res(1'b0, '0, '0, '0, ST_OK, 0);
        for (int k = 0; k < 8; k++) key_pool[k] = $urandom;

        add_row(mk_req(KIND_POP, '0, '0, '0, 0), 1, mk_res(0, '0, '0, '0, ST_EMPTY, 0));
        add_row(mk_req(KIND_PEEK, '0, '0, '0, 0), 1, mk_res(0, '0, '0, '0, ST_EMPTY, 0));
        add_row(mk_req(KIND_LOOKUP, '0, '0, '0, 0), 1, mk_res(0, '0, '0, '0, ST_OK, 0));
        add_row(mk_req(KIND_EXIT, '0, '0, '0, 0), 1, mk_res(0, '0, '0, '0, ST_EMPTY, 0));
        add_row(mk_req(KIND_POP_TO, '0, '0, '0, -1), 1, mk_res(0, '0, '0, '0, ST_OK, 0));
        add_row(mk_req(3'd6, '1, '1, '1, -1), 1, mk_res(0, '0, '0, '0, ST_OK, 0));
        add_row(mk_req(KIND_PUSH, '1, '1, '1, -1), 1, mk_res(0, '0, '0, '0, ST_OK, 1));
        add_row(mk_req(KIND_PEEK, '0, '0, '0, 0), 1, mk_res(1, '1, '1, '1, ST_OK, 1));
        add_row(mk_req(KIND_PUSH, '0, '0, '0, 63), 1, mk_res(0, '0, '0, '0, ST_OK, 2));
        add_row(mk_req(KIND_LOOKUP, '1, '0, '0, 0), 0, none);
        add_row(mk_req(KIND_PUSH, 32'd5, 4'd1, 32'h11, 0), 0, none);
        add_row(mk_req(KIND_PUSH, 32'd6, 4'd2, 32'h22, 0), 0, none);
        add_row(mk_req(KIND_PUSH, 32'd7, 4'd3, 32'h33, 0), 0, none);
        add_row(mk_req(KIND_LOOKUP, 32'd6, '0, '0, 0), 0, none);
        add_row(mk_req(KIND_LOOKUP, 32'd7, '0, '0, 0), 0, none);
        add_row(mk_req(KIND_LOOKUP, 32'd0, '0, '0, 0), 0, none);
        add_row(mk_req(KIND_POP_TO, '0, '0, '0, 63), 0, none);
        add_row(mk_req(KIND_EXIT, '0, 4'd1, '0, 0), 0, none);
        add_row(mk_req(KIND_POP, '0, '0, '0, 0), 0, none);
        add_row(mk_req(3'd7, '0, '0, '0, 0), 0, none);
        add_row(mk_req(KIND_PUSH, 32'ha5a5a5a5, 4'd5, 32'h5a5a5a5a, 0), 0, none);
        add_row(mk_req(KIND_PUSH, 32'h5a5a5a5a, 4'd10, 32'ha5a5a5a5, 0), 0, none);
        add_row(mk_req(KIND_POP_TO, '0, '0, '0, -1), 0, none);
        add_row(mk_req(KIND_EXIT, '0, 4'd9, '0, 0), 0, none);
        add_row(mk_req(KIND_LOOKUP, '1, '0, '0, 0), 0, none);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < directed_reqs.size(); n++)
            send_req(directed_reqs[n], directed_fixed_on[n], directed_fixed[n]);
        drain_results();

        for (int seg = 0; seg < N_SEG; seg++) begin
            snd_idle = (seg < 2) ? 33 : (seg < 4) ? 64 : 0;
            rcv_idle = (seg < 2) ? 64 : (seg < 4) ? 33 : 0;
            write_cfg(CFG_STRONG, strong_set[seg]);
            write_cfg(CFG_WEAK, weak_set[seg]);
            // fill past the top to reach the full stack
            if (seg == 0 || seg == 3) begin
                for (int n = 0; n < 70; n++) begin
                    r = mk_req(KIND_PUSH, pick_key(), pick_type(), $urandom, 0);
                    send_req(r, 0, none);
                end
            end
            push_pct = 50;
            for (int n = 0; n < SEG_LEN; n++) begin
                if (n % 60 == 0) begin
                    case ($urandom_range(2))
                        0: push_pct = 25;
                        1: push_pct = 50;
                        default: push_pct = 80;
                    endcase
                end
                send_req(gen_request(push_pct), 0, none);
            end
            drain_results();
        end

        repeat (80) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

/* scoped_symbol_stack_top.f */
hdl/sss_pkg.sv
hdl/sss_ctrl.sv
hdl/sss_datapath.sv
hdl/scoped_symbol_stack_top.sv
sim/tb_top.sv
